>>> sv/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;

    // Sequence length codes held by the front end
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    // Byte classification masks and tags
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] PAY2_MASK  = 8'h1F;
    localparam logic [7:0] PAY3_MASK  = 8'h0F;
    localparam logic [7:0] PAY4_MASK  = 8'h07;
    localparam logic [7:0] TERMINATOR = 8'h00;

    localparam logic [CP_W-1:0] REPL_CHAR = 21'h00003F;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One classified byte: some replacement marks, then an optional tail result
    typedef struct packed {
        logic [1:0]      rep_count;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_repl;
    } utf8d_job_t;

endpackage

`default_nettype wire

>>> sv/utf8d_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface utf8d_byte_if;
    import utf8d_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface utf8d_cp_if;
    import utf8d_pkg::*;
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] codepoint;
    logic            replaced;
    logic            last_in_run;

    modport source (output valid, output codepoint, output replaced, output last_in_run,
                    input ready);
    modport sink   (input valid, input codepoint, input replaced, input last_in_run,
                    output ready);
endinterface

`default_nettype wire

>>> sv/utf8d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_front
    import utf8d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    utf8d_byte_if.sink      bytes,
    input  wire logic       queue_full,
    output      logic       push,
    output      utf8d_job_t job
);

    logic [2:0]        seq_len_reg, seq_len_next;
    logic [1:0]        taken_reg, taken_next;
    logic [CP_W-1:0]   partial_reg, partial_next;
    logic              accept;
    logic              is_cont;
    logic              fresh;
    logic [1:0]        taken_inc;
    logic [CP_W-1:0]   partial_shift;
    logic [BYTE_W-1:0] b;

    assign b            = bytes.text_byte;
    assign bytes.ready  = !queue_full;
    assign accept       = bytes.valid && !queue_full;
    assign is_cont      = (b & CONT_MASK) == CONT_TAG;
    assign taken_inc    = taken_reg + 2'd1;
    assign partial_shift = {partial_reg[CP_W-7:0], b[5:0]};

    always_comb
    begin
        seq_len_next = seq_len_reg;
        taken_next   = taken_reg;
        partial_next = partial_reg;
        job          = '0;
        fresh        = 1'b1;

        if (seq_len_reg != SEQ_NONE)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (({1'b0, taken_inc} + 3'd1) >= seq_len_reg)
                begin
                    job.has_tail = 1'b1;
                    job.tail_cp  = partial_shift;
                    seq_len_next = SEQ_NONE;
                    taken_next   = '0;
                    partial_next = '0;
                end
                else
                begin
                    taken_next   = taken_inc;
                    partial_next = partial_shift;
                end
            end
            else
            begin
                // broken sequence: mark the lead and each continuation taken
                job.rep_count = taken_inc;
                seq_len_next  = SEQ_NONE;
                taken_next    = '0;
                partial_next  = '0;
            end
        end

        if (fresh)
        begin
            if (b == TERMINATOR)
            begin
                job.has_tail = 1'b0;
            end
            else if ((b & ASCII_MASK) == '0)
            begin
                job.has_tail = 1'b1;
                job.tail_cp  = CP_W'(b);
            end
            else if ((b & LEAD2_MASK) == LEAD2_TAG)
            begin
                seq_len_next = SEQ_LEN2;
                taken_next   = '0;
                partial_next = CP_W'(b & PAY2_MASK);
            end
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
            begin
                seq_len_next = SEQ_LEN3;
                taken_next   = '0;
                partial_next = CP_W'(b & PAY3_MASK);
            end
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
            begin
                seq_len_next = SEQ_LEN4;
                taken_next   = '0;
                partial_next = CP_W'(b & PAY4_MASK);
            end
            else
            begin
                job.has_tail  = 1'b1;
                job.tail_cp   = REPL_CHAR;
                job.tail_repl = 1'b1;
            end
        end
    end

    // drop jobs that produce nothing
    assign push = accept && ((job.rep_count != '0) || job.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= SEQ_NONE;
            taken_reg   <= '0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            taken_reg   <= taken_next;
            partial_reg <= partial_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/utf8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_queue
    import utf8d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire utf8d_job_t  job_in,
    output      logic        full,
    output      logic        not_empty,
    output      utf8d_job_t  head,
    input  wire logic        pop
);

    utf8d_job_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/utf8d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_back
    import utf8d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    input  wire utf8d_job_t job,
    output      logic       pop,
    utf8d_cp_if.source      codepoints
);

    logic            valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            repl_reg;
    logic            last_reg;
    logic [1:0]      idx_reg, idx_next;
    logic            load;
    logic [CP_W-1:0] item_cp;
    logic            item_repl;
    logic            item_last;

    always_comb
    begin
        if (idx_reg < job.rep_count)
        begin
            item_cp   = REPL_CHAR;
            item_repl = 1'b1;
            item_last = ((idx_reg + 2'd1) == job.rep_count) && !job.has_tail;
        end
        else
        begin
            item_cp   = job.tail_cp;
            item_repl = job.tail_repl;
            item_last = 1'b1;
        end
    end

    // advance whenever a job waits and the output slot is free or being emptied
    assign load = job_valid && (!valid_reg || codepoints.ready);
    assign pop  = load && item_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = item_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (codepoints.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= item_cp;
            repl_reg <= item_repl;
            last_reg <= item_last;
        end
    end

    assign codepoints.valid       = valid_reg;
    assign codepoints.codepoint   = cp_reg;
    assign codepoints.replaced    = repl_reg;
    assign codepoints.last_in_run = last_reg;

endmodule

`default_nettype wire

>>> sv/utf8_codepoint_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to codepoint decoder. Feed one text byte per transaction on the
// bytes channel; decoded codepoints leave on the codepoints channel, each
// with a replaced flag and last_in_run set on the final result of the byte
// that caused it. Lead and continuation bytes of an unfinished sequence give
// no result; byte 0 ends the text, flushing any open sequence as '?' marks.
// A well-formed stream is taken at one byte per cycle while the codepoints
// channel keeps taking results. A result is registered in the job queue and
// then in the output register before it is presented. A malformed byte can
// produce up to four results; the output stage issues one result per cycle
// while the codepoints channel is ready. The job being expanded stays at the
// head of the two-entry job queue until its last result is issued, so input
// runs on for one further byte that yields results (and any bytes that yield
// none) and then stalls until the burst has finished.
module utf8_codepoint_decoder
    import utf8d_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    utf8d_byte_if.sink  bytes,
    utf8d_cp_if.source  codepoints
);

    utf8d_job_t front_job;
    utf8d_job_t head_job;
    logic       front_push;
    logic       queue_full;
    logic       queue_valid;
    logic       back_pop;

    // Classify each byte and track the open sequence
    utf8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .queue_full (queue_full),
        .push       (front_push),
        .job        (front_job)
    );

    // Hold classified jobs so either side can stall on its own
    utf8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .job_in    (front_job),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head      (head_job),
        .pop       (back_pop)
    );

    // Expand each job into its results, one per cycle while the output is ready
    utf8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (queue_valid),
        .job        (head_job),
        .pop        (back_pop),
        .codepoints (codepoints)
    );

endmodule

`default_nettype wire

>>> sv/utf8d_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_checker
    import utf8d_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic [CP_W-1:0] codepoint,
    input wire logic            replaced,
    input wire logic            last_in_run
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(codepoint)
            && $stable(replaced) && $stable(last_in_run))
    else $error("stalled result changed");

    // a replacement always carries '?'
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && replaced |-> codepoint == REPL_CHAR)
    else $error("replacement without question mark");

    // a decoded codepoint always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !replaced |-> last_in_run)
    else $error("decoded codepoint not last in run");

    // the rest of a run follows without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_in_run |=> out_valid)
    else $error("gap inside a run");

endmodule

bind utf8_codepoint_decoder utf8d_checker u_utf8d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (codepoints.valid),
    .out_ready   (codepoints.ready),
    .codepoint   (codepoints.codepoint),
    .replaced    (codepoints.replaced),
    .last_in_run (codepoints.last_in_run)
);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import utf8d_pkg::*;

    // One decoded codepoint as it should leave the block
    typedef struct packed {
        logic [CP_W-1:0] codepoint;
        logic            replaced;
        logic            last_in_run;
    } cp_result_t;

    // Scoreboard: tracks the decoder state and queues the codepoints due out.
    class codepoint_scoreboard;
        cp_result_t      expected_q[$];
        logic [2:0]      seq_len;
        logic [1:0]      taken;
        logic [CP_W-1:0] partial;
        int              n_bytes;
        int              n_results;
        int              n_repl;
        int              n_fail;

        function new();
            seq_len   = SEQ_NONE;
            taken     = 2'd0;
            partial   = '0;
            n_bytes   = 0;
            n_results = 0;
            n_repl    = 0;
            n_fail    = 0;
        endfunction

        function void push(logic [CP_W-1:0] cp, logic repl);
            cp_result_t r;
            r.codepoint   = cp;
            r.replaced    = repl;
            r.last_in_run = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void flag_last(int first);
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last_in_run = 1'b1;
        endfunction

        // Advance the decoder by one accepted byte
        function void note_byte(logic [BYTE_W-1:0] b);
            int first;
            bit cont;
            first = expected_q.size();
            cont  = (b & CONT_MASK) == CONT_TAG;
            n_bytes++;
            if (seq_len != SEQ_NONE) begin
                if (cont) begin
                    partial = {partial[CP_W-7:0], b[5:0]};
                    taken   = taken + 2'd1;
                    if (int'(taken) + 1 >= int'(seq_len)) begin
                        push(partial, 1'b0);
                        seq_len = SEQ_NONE;
                        taken   = 2'd0;
                        partial = '0;
                    end
                    flag_last(first);
                    return;
                end
                // broken sequence: one mark for the lead, one per continuation
                for (int i = 0; i <= int'(taken); i++)
                    push(REPL_CHAR, 1'b1);
                seq_len = SEQ_NONE;
                taken   = 2'd0;
                partial = '0;
            end
            if (b == TERMINATOR) begin
                // ends the text, nothing of its own
            end else if ((b & ASCII_MASK) == 8'h00) begin
                push(CP_W'(b), 1'b0);
            end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
                seq_len = SEQ_LEN2;
                partial = CP_W'(b & PAY2_MASK);
            end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
                seq_len = SEQ_LEN3;
                partial = CP_W'(b & PAY3_MASK);
            end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
                seq_len = SEQ_LEN4;
                partial = CP_W'(b & PAY4_MASK);
            end else begin
                push(REPL_CHAR, 1'b1);
            end
            flag_last(first);
        endfunction

        function void check_result(logic [CP_W-1:0] cp, logic repl, logic last_in_run);
            cp_result_t want;
            n_results++;
            if (repl)
                n_repl++;
            if (expected_q.size() == 0) begin
                if (n_fail < 10)
                    $display("%0t: unexpected codepoint %h repl=%b last=%b",
                             $realtime, cp, repl, last_in_run);
                n_fail++;
                return;
            end
            want = expected_q.pop_front();
            if (want.codepoint !== cp || want.replaced !== repl
                    || want.last_in_run !== last_in_run) begin
                if (n_fail < 10)
                    $display("%0t: mismatch exp cp=%h repl=%b last=%b, got cp=%h repl=%b last=%b",
                             $realtime, want.codepoint, want.replaced, want.last_in_run,
                             cp, repl, last_in_run);
                n_fail++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   fast_in;
    bit   fast_out;
    bit   drained_once;

    codepoint_scoreboard sb;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    utf8_codepoint_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (byte_ch.sink),
        .codepoints (cp_ch.source)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Draw a wait for one transaction; a fast stretch runs with no wait at all
    function automatic int draw_wait(bit fast);
        if (fast)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // Offer one byte and hold it until the decoder takes it. Valid is only
    // dropped when a gap is due, so back-to-back transactions keep it high.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 19) == 0)
            fast_in = ~fast_in;
        gap = draw_wait(fast_in);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.text_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [BYTE_W-1:0] lead_byte(int len);
        case (len)
            2:       return LEAD2_TAG | 8'($urandom_range(0, 31));
            3:       return LEAD3_TAG | 8'($urandom_range(0, 15));
            default: return LEAD4_TAG | 8'($urandom_range(0, 7));
        endcase
    endfunction

    // Send a lead and n_cont continuations; break it with a non-continuation
    // byte if asked (that byte may be the terminator, ASCII, a lead or junk).
    task automatic send_sequence(input int len, input int n_cont, input bit do_break);
        logic [BYTE_W-1:0] b;
        send_byte(lead_byte(len));
        for (int i = 0; i < n_cont; i++)
            send_byte(cont_byte());
        if (do_break) begin
            b = 8'($urandom_range(0, 255));
            while ((b & CONT_MASK) == CONT_TAG)
                b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    // Hold the sender until every expected codepoint has come out
    task automatic drain_outputs();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Sink side: stall a random number of cycles before each transaction,
    // with occasional stretches of constant readiness.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0)
                fast_out = ~fast_out;
            stall = draw_wait(fast_out);
            if (stall > 0) begin
                cp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!cp_ch.valid)
                @(posedge clk);
            sb.check_result(cp_ch.codepoint, cp_ch.replaced, cp_ch.last_in_run);
        end
    end

    // Main stimulus
    initial
    begin
        logic [BYTE_W-1:0] directed_bytes [$];
        int pick;
        int len;
        int n_target;

        // Extremes of ASCII, a stray continuation, an invalid lead, the
        // longest codepoint, broken sequences with and without continuations,
        // a terminator flushing an open sequence and a lead breaking a lead.
        directed_bytes = '{
            8'h00, 8'h7F, 8'h80, 8'hFE,
            8'hC2, 8'hA9,
            8'hE2, 8'h82, 8'hAC,
            8'hF7, 8'hBF, 8'hBF, 8'hBF,
            8'hF4, 8'h8F, 8'h8F, 8'h41,
            8'hE1, 8'h00,
            8'hC3, 8'hC3, 8'hA0
        };

        sb                = new();
        fast_in           = 1'b0;
        fast_out          = 1'b0;
        drained_once      = 1'b0;
        rst_n             = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.text_byte = '0;
        cp_ch.ready       = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // Random part: mostly well-formed text, the rest terminators, broken
        // sequences and raw noise.
        n_target = 310;
        while (sb.n_bytes < n_target) begin
            if (!drained_once && sb.n_bytes >= n_target / 2) begin
                drain_outputs();
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (pick < 45) begin
                send_sequence(2, 1, 1'b0);
            end else if (pick < 60) begin
                send_sequence(3, 2, 1'b0);
            end else if (pick < 72) begin
                send_sequence(4, 3, 1'b0);
            end else if (pick < 78) begin
                send_byte(TERMINATOR);
            end else if (pick < 88) begin
                len = $urandom_range(2, 4);
                send_sequence(len, $urandom_range(0, len - 2), 1'b1);
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end

        // Drop valid, let the tail drain, then wait a while longer for strays
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d text bytes, checked %0d codepoints (%0d replacements).",
                 sb.n_bytes, sb.n_results, sb.n_repl);
        $display("Failures: %0d, codepoints still owed: %0d.",
                 sb.n_fail, sb.expected_q.size());
        if (sb.n_fail == 0 && sb.expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Timed out with %0d codepoints still owed.", sb.expected_q.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/utf8d_pkg.sv
sv/utf8d_if.sv
sv/utf8d_front.sv
sv/utf8d_queue.sv
sv/utf8d_back.sv
sv/utf8_codepoint_decoder.sv
sv/utf8d_checker.sv
sim/testbench.sv
